>>> hw/rtl/b64d_pkg.sv
// Shared types, constants and the alphabet map of the Base64 decoder.
package b64d_pkg;

  localparam logic [7:0] SYM_INVALID = 8'd255;
  localparam logic [7:0] SYM_PAD     = 8'd254;
  localparam logic [7:0] SYM_PLUS    = 8'd62;
  localparam logic [7:0] SYM_SLASH   = 8'd63;

  localparam logic [1:0] PAD_MAX     = 2'd3;
  localparam logic [1:0] SYM_LAST    = 2'd3;

  localparam int unsigned Q_DEPTH    = 2;

  // One decoded group: 24 bits and how many of its bytes go out (1..3).
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  count;
  } b64d_group_t;

  // Character code to 6-bit value, or SYM_PAD / SYM_INVALID.
  function automatic logic [7:0] b64d_map(input logic [7:0] c);
    logic [7:0] r;
    case (c) inside
      [8'h41:8'h5A]: r = c - 8'h41;
      [8'h61:8'h7A]: r = c - 8'h61 + 8'd26;
      [8'h30:8'h39]: r = c - 8'h30 + 8'd52;
      8'h2B:         r = SYM_PLUS;
      8'h2F:         r = SYM_SLASH;
      8'h3D:         r = SYM_PAD;
      default:       r = SYM_INVALID;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/b64d_if.sv
// Valid/ready channel interfaces for characters in and bytes out.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_run;

  modport source (output valid, output data_byte, output last_of_run, input ready);
  modport sink   (input valid, input data_byte, input last_of_run, output ready);
endinterface

>>> hw/rtl/b64d_front.sv
// Front end: takes characters, maps them, accumulates groups of four symbols.
module b64d_front
  import b64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  b64d_char_if.sink        char_in,
  input  logic             q_full,
  output logic             q_push,
  output b64d_group_t      q_wr
);

  logic [23:0] acc;
  logic [1:0]  sym_cnt;
  logic [1:0]  pad_cnt;

  logic [7:0]  code;
  logic        sym_ok;
  logic        is_pad;
  logic [5:0]  sym6;
  logic [23:0] acc_next;
  logic [1:0]  pad_next;
  logic [1:0]  grp_count;
  logic        fire;

  assign char_in.ready = !q_full;
  assign fire   = char_in.valid && char_in.ready;

  assign code   = b64d_map(char_in.char_code);
  assign sym_ok = (code != SYM_INVALID);
  assign is_pad = (code == SYM_PAD);
  assign sym6   = is_pad ? 6'd0 : code[5:0];

  assign acc_next = {acc[17:0], sym6};
  assign pad_next = (is_pad && pad_cnt != PAD_MAX) ? pad_cnt + 2'd1 : pad_cnt;

  assign q_push = fire && sym_ok && (sym_cnt == SYM_LAST);
  assign q_wr   = '{bits: acc_next, count: grp_count};
  always_comb begin
    case (pad_next)
      2'd0:    grp_count = 2'd3;
      2'd1:    grp_count = 2'd2;
      default: grp_count = 2'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      sym_cnt <= '0;
      pad_cnt <= '0;
    end else if (fire && sym_ok) begin
      if (sym_cnt == SYM_LAST) begin
        acc     <= '0;
        sym_cnt <= '0;
        pad_cnt <= '0;
      end else begin
        acc     <= acc_next;
        sym_cnt <= sym_cnt + 2'd1;
        pad_cnt <= pad_next;
      end
    end
  end

endmodule

>>> hw/rtl/b64d_queue.sv
// Small register FIFO of decoded groups between front and back end.
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned QueueDepth = Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64d_group_t wr,
  input  logic        pop,
  output b64d_group_t head,
  output logic        full,
  output logic        empty
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  b64d_group_t     slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full  = (fill == CntFull);
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrOne;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrOne;
      end
      case ({push, pop})
        2'b10:   fill <= fill + CntOne;
        2'b01:   fill <= fill - CntOne;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hw/rtl/b64d_back.sv
// Back end: holds one group and sends its bytes out one per transfer.
module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  b64d_group_t q_head,
  output logic        q_pop,
  b64d_byte_if.source byte_out
);

  logic        cur_valid;
  b64d_group_t cur;
  logic [1:0]  idx;
  logic        is_last;
  logic        fire;

  assign is_last = ((idx + 2'd1) == cur.count);
  assign fire    = byte_out.valid && byte_out.ready;
  assign q_pop   = !q_empty && (!cur_valid || (fire && is_last));

  assign byte_out.valid       = cur_valid;
  assign byte_out.last_of_run = is_last;
  always_comb begin
    case (idx)
      2'd0:    byte_out.data_byte = cur.bits[23:16];
      2'd1:    byte_out.data_byte = cur.bits[15:8];
      default: byte_out.data_byte = cur.bits[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (fire) begin
      if (is_last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

endmodule

>>> hw/rtl/base64_stream_decoder.sv
// Top level of the Base64 stream decoder: front end, group queue, back end.
//
//  channel    dir  payload                       per transfer
//  char_in    in   char_code[7:0]                one character
//  byte_out   out  data_byte[7:0], last_of_run   one decoded byte
//
// One character is taken per cycle; the front end stalls only when the group
// queue is full. Each fourth valid symbol writes a group to the queue, which
// the back end drains at one byte per cycle while byte_out is ready, 1 to 3
// bytes per group. With the back end idle, a group passes from its queue slot
// into the back end's holding register before its first byte can transfer.
// Synchronous reset clears the accumulator, counts, queue and output valid.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned QueueDepth = Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   char_in,
  b64d_byte_if.source byte_out
);

  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  b64d_group_t q_wr;
  b64d_group_t q_head;

  b64d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wr    (q_wr)
  );

  b64d_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wr    (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .byte_out (byte_out)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("group queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("group queue read while empty");

  a_group_count: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_wr.count != 2'd0))
    else $error("group with no bytes");

endmodule
